/* src/smds_pkg.sv */
// smds_pkg: operation and status codes and the slot layout shared by the
// sparse matrix default store. No dependencies.
`timescale 1ns / 1ps

package smds_pkg;

  localparam int unsigned DataW = 16;

  // operation codes
  localparam logic [1:0] OpStore = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpFind  = 2'd2;

  // status codes
  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] row;
    logic [DataW-1:0] column;
    logic [DataW-1:0] value;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

endpackage

/* src/smds_ram.sv */
// smds_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module smds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sparse_matrix_default_store_unit.sv */
// sparse_matrix_default_store_unit: sparse matrix held in a table of slots,
// absent cells read as a configured default value.
// Depends on smds_pkg and smds_ram.
//
// Usage:
//   Request channel (in_valid_i / in_ready_o) carries operation_i, row_i,
//   column_i and value_i: store a cell, read a cell, or find the cell that
//   holds a value. Each request gives exactly one response on the response
//   channel (out_valid_o / out_ready_i): read_value_o, found_row_o,
//   found_column_o, hit_o and status_o.
//   Every request sweeps all CAPACITY slots through the slot RAM read port,
//   one slot a cycle, then finishes the last read in S_DRAIN and commits in
//   S_DONE, which sets out_valid_o. in_ready_o is high only while the
//   sequencer is idle, so a request is not taken before the previous one has
//   committed; the sweep is serial because of the single RAM read port.
//   The response sits in an output register; the next request is taken while
//   it waits. A stalled receiver holds the following request in its commit
//   cycle until the register frees.
//   After reset the slot RAM is cleared, one slot a cycle, through all CAPACITY slots
//   with in_ready_o low; cfg_we_i / cfg_wdata_i write the default value at
//   any time (reset value zero), and should change only while idle.
`timescale 1ns / 1ps

module sparse_matrix_default_store_unit #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [smds_pkg::DataW-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [smds_pkg::DataW-1:0] row_i,
  input  logic [smds_pkg::DataW-1:0] column_i,
  input  logic [smds_pkg::DataW-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [smds_pkg::DataW-1:0] read_value_o,
  output logic [smds_pkg::DataW-1:0] found_row_o,
  output logic [smds_pkg::DataW-1:0] found_column_o,
  output logic                  hit_o,
  output logic [1:0]            status_o
);

  import smds_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e state_q;

  logic [DataW-1:0] dflt_q;
  logic [1:0]       op_q;
  logic [DataW-1:0] row_q, col_q, val_q;
  logic [IdxW-1:0]  addr_q;
  logic             rd_pend_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic             found_q, empty_q;
  logic [IdxW-1:0]  found_idx_q, empty_idx_q;
  slot_t            found_ent_q;

  logic             out_valid_q;
  logic [DataW-1:0] rd_val_q, fr_q, fc_q;
  logic             hit_q;
  logic [1:0]       st_q;

  // slot RAM
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr;
  slot_t            ram_wdata, ram_rdata;

  smds_ram #(
    .Width (SlotW),
    .Depth (CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign ram_re = (state_q == S_SWEEP);

  // shared compare unit: key match against the slot coming out of the RAM
  logic match;
  always_comb begin
    match = 1'b0;
    case (op_q)
      OpStore, OpRead: match = ram_rdata.valid && (ram_rdata.row == row_q)
                               && (ram_rdata.column == col_q);
      OpFind:          match = ram_rdata.valid && (ram_rdata.value == val_q);
      default:         match = 1'b0;
    endcase
  end

  // commit logic
  logic       done_fire;
  logic       cmt_we;
  logic [IdxW-1:0] cmt_addr;
  slot_t      cmt_data;
  logic [DataW-1:0] res_rd, res_fr, res_fc;
  logic       res_hit;
  logic [1:0] res_st;

  assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmt_we   = 1'b0;
    cmt_addr = found_idx_q;
    cmt_data = '{valid: 1'b1, row: row_q, column: col_q, value: val_q};
    res_rd   = '0;
    res_fr   = '0;
    res_fc   = '0;
    res_hit  = 1'b0;
    res_st   = StMiss;
    case (op_q)
      OpStore: begin
        if (val_q != dflt_q) begin
          if (found_q) begin
            cmt_we = 1'b1;
            res_st = StDone;
          end else if (empty_q) begin
            cmt_we   = 1'b1;
            cmt_addr = empty_idx_q;
            res_st   = StDone;
          end else begin
            res_st = StFull;
          end
        end else if (found_q) begin
          // storing the default frees the slot
          cmt_we         = 1'b1;
          cmt_data.valid = 1'b0;
          res_st         = StDone;
        end
      end
      OpRead: begin
        if (found_q) begin
          res_rd  = found_ent_q.value;
          res_hit = 1'b1;
          res_st  = StDone;
        end else begin
          res_rd = dflt_q;
        end
      end
      OpFind: begin
        if (found_q) begin
          res_fr  = found_ent_q.row;
          res_fc  = found_ent_q.column;
          res_hit = 1'b1;
          res_st  = StDone;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = cmt_we && done_fire;
      ram_waddr = cmt_addr;
      ram_wdata = cmt_data;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      dflt_q      <= '0;
      addr_q      <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      rd_pend_q <= (state_q == S_SWEEP);
      rd_idx_q  <= addr_q;

      // track first matching slot and first empty slot
      if (rd_pend_q) begin
        if (match && !found_q) begin
          found_q     <= 1'b1;
          found_idx_q <= rd_idx_q;
          found_ent_q <= ram_rdata;
        end
        if (!ram_rdata.valid && !empty_q) begin
          empty_q     <= 1'b1;
          empty_idx_q <= rd_idx_q;
        end
      end

      case (state_q)
        S_CLEAR: begin
          if (addr_q == LastIdx) begin
            addr_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= operation_i;
            row_q   <= row_i;
            col_q   <= column_i;
            val_q   <= value_i;
            found_q <= 1'b0;
            empty_q <= 1'b0;
            addr_q  <= '0;
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (addr_q == LastIdx) begin
            addr_q  <= '0;
            state_q <= S_DRAIN;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            out_valid_q <= 1'b1;
            rd_val_q    <= res_rd;
            fr_q        <= res_fr;
            fc_q        <= res_fc;
            hit_q       <= res_hit;
            st_q        <= res_st;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = rd_val_q;
  assign found_row_o    = fr_q;
  assign found_column_o = fc_q;
  assign hit_o          = hit_q;
  assign status_o       = st_q;

endmodule
